// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under active-low reset.
`define TVN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under active-low reset.
`define TVN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tvn_pkg.sv
// Types and constants for the terrain value noise generator.
`default_nettype none
package tvn_pkg;

  localparam logic [16:0] Q_ONE = 17'd65536;

  localparam logic [31:0] HASH_X = 32'd374761393;
  localparam logic [31:0] HASH_Z = 32'd668265263;
  localparam logic [31:0] HASH_M = 32'd1274126177;

  localparam int NUM_NOISE = 6;
  localparam int NOISE_F [NUM_NOISE] = '{96, 28, 8, 36, 18, 14};
  localparam logic [31:0] NOISE_SALT [NUM_NOISE] =
    '{32'd17, 32'd53, 32'd131, 32'd181, 32'd227, 32'd269};
  localparam int N_MACRO = 0;
  localparam int N_MEDIUM = 1;
  localparam int N_DETAIL = 2;
  localparam int N_HUMID = 3;
  localparam int N_ROUGH = 4;
  localparam int N_COAST = 5;

  localparam int FR_W = 7;

  localparam logic [15:0] W_MACRO = 16'd36700;
  localparam logic [15:0] W_MEDIUM = 16'd14418;
  localparam logic [15:0] W_RIDGE = 16'd11796;
  localparam logic [15:0] W_ORIGIN = 16'd19661;

  localparam int SQ_RAD_W = 50;
  localparam int SQ_ROOT_W = 25;
  localparam int SQ_REM_W = 27;

  localparam logic [9:0] BIAS_LIM = 10'd402;
  localparam logic [18:0] D2_LIM = 19'd161604;
  localparam logic [SQ_ROOT_W-1:0] R_KNEE = SQ_ROOT_W'(234 * 65536);
  localparam logic [31:0] M_KNEE_DIV = 32'(((64'd1 << 32) + 64'd167) / 64'd168);

  localparam logic [21:0] COAST_LIM = 22'd851968;
  localparam logic [21:0] HUMID_LIM = 22'd720896;
  localparam logic [21:0] ROUGH_LIM = 22'd196608;

  localparam logic [7:0] H_WATER = 8'd62;
  localparam logic [7:0] H_PLAINS = 8'd92;
  localparam logic [7:0] H_FOREST = 8'd148;
  localparam logic [7:0] H_HILL = 8'd200;

  localparam int LAT_NOISE = 9;
  localparam int LAT_BIAS = 3 + SQ_ROOT_W + 5;
  localparam int LAT_MIX = 5;

  typedef enum logic [2:0] {
    TER_WATER  = 3'd0,
    TER_PLAINS = 3'd1,
    TER_FOREST = 3'd2,
    TER_HILL   = 3'd3,
    TER_RIDGE  = 3'd4
  } biome_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_RAD_W-1:0]  rad;
  } sq_t;

endpackage
`default_nettype wire

// File: hw/rtl/tvn_smooth.sv
// Two-stage smoothstep on a Q16 value.
`default_nettype none
module tvn_smooth import tvn_pkg::*; (
  input  logic        clk,
  input  logic [16:0] t,
  output logic [16:0] s
);

  logic [16:0] tc_nxt, tc_r;
  logic [33:0] tt_nxt, tt_r;
  logic [17:0] w;
  logic [51:0] p;
  logic [16:0] s_r;

  always_comb begin
    tc_nxt = (t > Q_ONE) ? Q_ONE : t;
    tt_nxt = 34'(tc_nxt) * 34'(tc_nxt);
    w = 18'd196608 - {tc_r, 1'b0};
    p = 52'(tt_r) * 52'(w);
  end

  always_ff @(posedge clk) begin
    tc_r <= tc_nxt;
    tt_r <= tt_nxt;
    s_r <= p[48:32];
  end

  assign s = s_r;

endmodule
`default_nettype wire

// File: hw/rtl/tvn_noise.sv
// Pipelined seeded value-noise sample with smoothstep bilinear interpolation.
`default_nettype none
module tvn_noise import tvn_pkg::*; #(
  parameter int WW = 21,
  parameter int F = 96,
  parameter logic [31:0] SALT = 32'd17
) (
  input  logic                 clk,
  input  logic signed [WW-1:0] wx,
  input  logic signed [WW-1:0] wz,
  input  logic [31:0]          seed,
  output logic [16:0]          value
);

  localparam logic [63:0] M_F64 = ((64'd1 << 32) + 64'(F) - 64'd1) / 64'(F);
  localparam logic [31:0] M_F = M_F64[31:0];
  localparam logic [WW-1:0] F_W = WW'(F);

  function automatic logic [16:0] lerp(input logic [16:0] a, input logic [16:0] b,
                                       input logic [16:0] t);
    logic signed [17:0] d;
    logic signed [35:0] p;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = 36'(d) * 36'($signed({1'b0, t}));
    lerp = a + 17'(p >>> 16);
  endfunction

  logic signed [WW-1:0] crd [2];
  logic [WW-1:0] mag1_nxt [2], mag1_r [2], mag2_r [2], q2_nxt [2], q2_r [2];
  logic neg1_r [2], neg2_r [2];
  logic [WW+31:0] qp [2];
  logic [WW-1:0] rm [2], cm [2];
  logic [FR_W-1:0] rem3_nxt [2], rem3_r [2];
  logic [31:0] c3_nxt [2], c3_r [2];
  logic [55:0] tp [2];
  logic [15:0] t4_nxt [2], t4_r [2];
  logic [31:0] a4_nxt [2], a4_r [2];
  logic [16:0] sm [2];
  logic [31:0] xa [4], za [4], hh [4], h5_nxt [4], h5_r [4], hm6_r [4], ff [4];
  logic [16:0] v7_nxt [4], v7_r [4];
  logic [16:0] sx7_r, sz7_r, sz8_r;
  logic [16:0] l8_nxt [2], l8_r [2];
  logic [16:0] val_r;

  assign crd[0] = wx;
  assign crd[1] = wz;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag1_nxt[i] = crd[i][WW-1] ? (~crd[i] + 1'b1) : crd[i];
      qp[i] = (WW+32)'(mag1_r[i]) * (WW+32)'(M_F);
      q2_nxt[i] = qp[i][WW+31:32];
      rm[i] = mag2_r[i] - q2_r[i] * F_W;
      rem3_nxt[i] = neg2_r[i] ? '0 : rm[i][FR_W-1:0];
      cm[i] = neg2_r[i] ? (~q2_r[i] + 1'b1) : q2_r[i];
      c3_nxt[i] = 32'($signed(cm[i]));
      tp[i] = 56'({rem3_r[i], 16'b0}) * 56'(M_F);
      t4_nxt[i] = tp[i][47:32];
    end
    a4_nxt[0] = c3_r[0] * HASH_X;
    a4_nxt[1] = c3_r[1] * HASH_Z;
    for (int k = 0; k < 4; k++) begin
      xa[k] = (k % 2 == 1) ? a4_r[0] + HASH_X : a4_r[0];
      za[k] = (k / 2 == 1) ? a4_r[1] + HASH_Z : a4_r[1];
      hh[k] = seed ^ SALT ^ xa[k] ^ za[k];
      h5_nxt[k] = hh[k] ^ (hh[k] >> 13);
      ff[k] = hm6_r[k] ^ (hm6_r[k] >> 16);
      v7_nxt[k] = {1'b0, ff[k][15:0]} + 17'(ff[k][15]);
    end
    l8_nxt[0] = lerp(v7_r[0], v7_r[1], sx7_r);
    l8_nxt[1] = lerp(v7_r[2], v7_r[3], sx7_r);
  end

  for (genvar g = 0; g < 2; g++) begin : g_sm
    tvn_smooth u_smooth (
      .clk (clk),
      .t   ({1'b0, t4_r[g]}),
      .s   (sm[g])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      mag1_r[i] <= mag1_nxt[i];
      neg1_r[i] <= crd[i][WW-1];
      mag2_r[i] <= mag1_r[i];
      neg2_r[i] <= neg1_r[i];
      q2_r[i] <= q2_nxt[i];
      rem3_r[i] <= rem3_nxt[i];
      c3_r[i] <= c3_nxt[i];
      t4_r[i] <= t4_nxt[i];
      a4_r[i] <= a4_nxt[i];
      l8_r[i] <= l8_nxt[i];
    end
    for (int k = 0; k < 4; k++) begin
      h5_r[k] <= h5_nxt[k];
      hm6_r[k] <= h5_r[k] * HASH_M;
      v7_r[k] <= v7_nxt[k];
    end
    sx7_r <= sm[0];
    sz7_r <= sm[1];
    sz8_r <= sz7_r;
    val_r <= lerp(l8_r[0], l8_r[1], sz8_r);
  end

  assign value = val_r;

endmodule
`default_nettype wire

// File: hw/rtl/tvn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tvn_isqrt import tvn_pkg::*; (
  input  logic                 clk,
  input  logic [SQ_RAD_W-1:0]  rad,
  output logic [SQ_ROOT_W-1:0] root
);

  function automatic sq_t sq_step(input sq_t a);
    sq_t b;
    logic [SQ_REM_W-1:0] sh;
    logic [SQ_REM_W-1:0] tr;
    sh = {a.rem[SQ_REM_W-3:0], a.rad[SQ_RAD_W-1 -: 2]};
    tr = {a.root, 2'b01};
    if (sh >= tr) begin
      b.rem = sh - tr;
      b.root = {a.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      b.rem = sh;
      b.root = {a.root[SQ_ROOT_W-2:0], 1'b0};
    end
    b.rad = {a.rad[SQ_RAD_W-3:0], 2'b00};
    return b;
  endfunction

  sq_t st_r [SQ_ROOT_W];
  sq_t st_in;

  assign st_in = '{rem: '0, root: '0, rad: rad};

  always_ff @(posedge clk) begin
    st_r[0] <= sq_step(st_in);
    for (int k = 1; k < SQ_ROOT_W; k++) begin
      st_r[k] <= sq_step(st_r[k-1]);
    end
  end

  assign root = st_r[SQ_ROOT_W-1].root;

endmodule
`default_nettype wire

// File: hw/rtl/tvn_bias.sv
// Radial origin bias: squared distance, square root, falloff and smoothstep.
`default_nettype none
module tvn_bias import tvn_pkg::*; #(
  parameter int WW = 21
) (
  input  logic                 clk,
  input  logic signed [WW-1:0] wx,
  input  logic signed [WW-1:0] wz,
  output logic [16:0]          bias
);

  logic [WW-1:0] mx, mz;
  logic [8:0] m1_r [2];
  logic far1_r, far2_r, far3_r;
  logic [18:0] d2_r;
  logic [SQ_RAD_W-1:0] rad3_r;
  logic [SQ_ROOT_W-1:0] root;
  logic far_d_r [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] diff_nxt, diff_r;
  logic farc_r;
  logic [49:0] up;
  logic [16:0] u_nxt, u_r, s;
  logic [16:0] bias_r;

  always_comb begin
    mx = wx[WW-1] ? (~wx + 1'b1) : wx;
    mz = wz[WW-1] ? (~wz + 1'b1) : wz;
    diff_nxt = (root > R_KNEE) ? root - R_KNEE : '0;
    up = 50'(diff_r) * 50'(M_KNEE_DIV);
    u_nxt = farc_r ? Q_ONE : {1'b0, up[47:32]};
  end

  tvn_isqrt u_isqrt (
    .clk  (clk),
    .rad  (rad3_r),
    .root (root)
  );

  tvn_smooth u_smooth (
    .clk (clk),
    .t   (u_r),
    .s   (s)
  );

  always_ff @(posedge clk) begin
    m1_r[0] <= mx[8:0];
    m1_r[1] <= mz[8:0];
    far1_r <= (mx >= WW'(BIAS_LIM)) || (mz >= WW'(BIAS_LIM));
    d2_r <= 19'(m1_r[0]) * 19'(m1_r[0]) + 19'(m1_r[1]) * 19'(m1_r[1]);
    far2_r <= far1_r;
    far3_r <= far2_r || (d2_r >= D2_LIM);
    rad3_r <= {d2_r[17:0], 32'b0};
    far_d_r[0] <= far3_r;
    for (int k = 1; k < SQ_ROOT_W; k++) begin
      far_d_r[k] <= far_d_r[k-1];
    end
    diff_r <= diff_nxt;
    farc_r <= far_d_r[SQ_ROOT_W-1];
    u_r <= u_nxt;
    bias_r <= Q_ONE - s;
  end

  assign bias = bias_r;

endmodule
`default_nettype wire

// File: hw/rtl/tvn_mix.sv
// Weighted mix to height, then biome selection.
`default_nettype none
module tvn_mix import tvn_pkg::*; (
  input  logic        clk,
  input  logic [16:0] macro_n,
  input  logic [16:0] medium_n,
  input  logic [16:0] detail_n,
  input  logic [16:0] humid_n,
  input  logic [16:0] rough_n,
  input  logic [16:0] coast_n,
  input  logic [16:0] bias,
  output logic [7:0]  height,
  output biome_t      biome
);

  logic [17:0] twice;
  logic [17:0] fold;
  logic [16:0] ridged_nxt;
  logic [16:0] macro1_r, medium1_r, ridged1_r, bias1_r;
  logic [32:0] p2_r [4];
  logic [34:0] acc;
  logic [16:0] land_nxt, land3_r;
  logic [25:0] lp;
  logic [7:0] h4_r, height_r;
  logic [2:0] fl_r [4];
  logic [2:0] fl_nxt;
  biome_t biome_nxt, biome_r;

  always_comb begin
    twice = {detail_n, 1'b0};
    fold = (twice >= 18'(Q_ONE)) ? twice - 18'(Q_ONE) : 18'(Q_ONE) - twice;
    ridged_nxt = Q_ONE - fold[16:0];
    fl_nxt[0] = (22'(coast_n) * 22'd25) > COAST_LIM;
    fl_nxt[1] = (22'(humid_n) * 22'd20) > HUMID_LIM;
    fl_nxt[2] = (22'(rough_n) * 22'd5) > ROUGH_LIM;
    acc = 35'(p2_r[0]) + 35'(p2_r[1]) + 35'(p2_r[2]) + 35'(p2_r[3]);
    land_nxt = (acc[34:16] > 19'(Q_ONE)) ? Q_ONE : acc[32:16];
    lp = {land3_r, 8'b0} - 26'(land3_r);
    if (h4_r < H_WATER) begin
      biome_nxt = TER_WATER;
    end else if (h4_r < H_PLAINS) begin
      biome_nxt = fl_r[3][0] ? TER_PLAINS : TER_WATER;
    end else if (h4_r < H_FOREST) begin
      biome_nxt = fl_r[3][1] ? TER_FOREST : TER_PLAINS;
    end else if (h4_r < H_HILL) begin
      biome_nxt = fl_r[3][2] ? TER_RIDGE : TER_HILL;
    end else begin
      biome_nxt = TER_RIDGE;
    end
  end

  always_ff @(posedge clk) begin
    macro1_r <= macro_n;
    medium1_r <= medium_n;
    ridged1_r <= ridged_nxt;
    bias1_r <= bias;
    fl_r[0] <= fl_nxt;
    for (int k = 1; k < 4; k++) begin
      fl_r[k] <= fl_r[k-1];
    end
    p2_r[0] <= 33'(macro1_r) * 33'(W_MACRO);
    p2_r[1] <= 33'(medium1_r) * 33'(W_MEDIUM);
    p2_r[2] <= 33'(ridged1_r) * 33'(W_RIDGE);
    p2_r[3] <= 33'(bias1_r) * 33'(W_ORIGIN);
    land3_r <= land_nxt;
    h4_r <= lp[23:16];
    height_r <= h4_r;
    biome_r <= biome_nxt;
  end

  assign height = height_r;
  assign biome = biome_r;

endmodule
`default_nettype wire

// File: hw/rtl/terrain_value_noise_generator_core.sv
// Top level of the terrain value noise generator.
//
// Usage: drive in_chunk_col/row and in_cell_col/row and pulse start; a
// transaction is taken at each clock edge with start high and busy low.
// busy stays low, so a new point may be given in every cycle.
// The result (out_height, out_biome) is shown with out_valid high for exactly
// one cycle; results come out in order.
// Throughput: one point per cycle. Latency is set by the origin-bias path:
// squared distance, a 25-stage square root (one root bit per stage),
// falloff divide and smoothstep. The six noise samples finish earlier and
// wait in a delay line.
// cfg_wr_en/cfg_wr_data write world_seed; write it only while idle.
// Reset (rst_n low, synchronous) clears the seed to 0 and drops all
// transactions in flight. The receiver cannot stall: results are never held.
`default_nettype none
`include "assert_macros.svh"
module terrain_value_noise_generator_core import tvn_pkg::*; #(
  parameter int CHUNK_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [14:0] in_chunk_col,
  input  logic [14:0] in_chunk_row,
  input  logic [4:0]  in_cell_col,
  input  logic [4:0]  in_cell_row,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  output logic [7:0]  out_height,
  output logic [2:0]  out_biome
);

  localparam int WW = 16 + $clog2(CHUNK_SIZE);
  localparam int LAT_TOTAL = 1 + LAT_BIAS + LAT_MIX;
  localparam int ND = LAT_BIAS - LAT_NOISE;
  localparam logic signed [WW-1:0] CS_S = WW'(CHUNK_SIZE);

  logic accept;
  logic [31:0] seed_r;
  logic [LAT_TOTAL-1:0] vld_nxt, vld_r;
  logic signed [WW-1:0] wx_nxt, wz_nxt, wx_r, wz_r;
  logic [16:0] nv [NUM_NOISE];
  logic [16:0] dl_r [ND][NUM_NOISE];
  logic [16:0] bias;
  logic [7:0] height;
  biome_t biome;

  assign busy = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    vld_nxt = {vld_r[LAT_TOTAL-2:0], accept};
    wx_nxt = WW'($signed(in_chunk_col)) * CS_S + $signed({{(WW-5){1'b0}}, in_cell_col});
    wz_nxt = WW'($signed(in_chunk_row)) * CS_S + $signed({{(WW-5){1'b0}}, in_cell_row});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wx_r <= wx_nxt;
    wz_r <= wz_nxt;
    dl_r[0] <= nv;
    for (int k = 1; k < ND; k++) begin
      dl_r[k] <= dl_r[k-1];
    end
  end

  for (genvar g = 0; g < NUM_NOISE; g++) begin : g_noise
    tvn_noise #(
      .WW   (WW),
      .F    (NOISE_F[g]),
      .SALT (NOISE_SALT[g])
    ) u_noise (
      .clk   (clk),
      .wx    (wx_r),
      .wz    (wz_r),
      .seed  (seed_r),
      .value (nv[g])
    );
  end

  tvn_bias #(
    .WW (WW)
  ) u_bias (
    .clk  (clk),
    .wx   (wx_r),
    .wz   (wz_r),
    .bias (bias)
  );

  tvn_mix u_mix (
    .clk      (clk),
    .macro_n  (dl_r[ND-1][N_MACRO]),
    .medium_n (dl_r[ND-1][N_MEDIUM]),
    .detail_n (dl_r[ND-1][N_DETAIL]),
    .humid_n  (dl_r[ND-1][N_HUMID]),
    .rough_n  (dl_r[ND-1][N_ROUGH]),
    .coast_n  (dl_r[ND-1][N_COAST]),
    .bias     (bias),
    .height   (height),
    .biome    (biome)
  );

  assign out_valid = vld_r[LAT_TOTAL-1];
  assign out_height = height;
  assign out_biome = biome;

  `TVN_ASSERT_IMP(a_out_has_source, clk, rst_n, out_valid, $past(accept && rst_n, LAT_TOTAL), "result without transaction")
  `TVN_ASSERT_IMP(a_low_is_water, clk, rst_n, out_valid && (out_height < H_WATER), out_biome == TER_WATER, "low point not water")
  `TVN_ASSERT_IMP(a_high_is_ridge, clk, rst_n, out_valid && (out_height >= H_HILL), out_biome == TER_RIDGE, "high point not ridge")
  `TVN_ASSERT_NXT(a_accept_flows, clk, rst_n, accept, vld_r[0], "accepted transaction lost")

endmodule
`default_nettype wire

// File: bench/tb_terrain_value_noise_generator_core.sv
// Testbench for terrain_value_noise_generator_core: directed and random points vs a predictor.
`timescale 1ns / 1ps
module tb_terrain_value_noise_generator_core;
  import tvn_pkg::*;

  typedef struct {
    logic [7:0] height;
    biome_t     biome;
  } terrain_pt_t;

  typedef struct {
    int         chunk_col;
    int         chunk_row;
    logic [4:0] cell_col;
    logic [4:0] cell_row;
  } point_row_t;

  localparam int DRAIN_CYCLES = 45;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [14:0] in_chunk_col = '0;
  logic [14:0] in_chunk_row = '0;
  logic [4:0]  in_cell_col = '0;
  logic [4:0]  in_cell_row = '0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        out_valid;
  logic [7:0]  out_height;
  logic [2:0]  out_biome;

  logic [31:0] seed_q = '0;
  terrain_pt_t pending_pts[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          allow_idle = 1'b1;

  always #6 clk = ~clk;

  terrain_value_noise_generator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_chunk_col(in_chunk_col), .in_chunk_row(in_chunk_row),
    .in_cell_col(in_cell_col), .in_cell_row(in_cell_row),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_height(out_height), .out_biome(out_biome)
  );

  function automatic longint unsigned corner_value(int x, int z, logic [31:0] salt);
    logic [31:0] h;
    logic [31:0] xm;
    logic [31:0] zm;
    longint unsigned n;
    xm = 32'(x) * HASH_X;
    zm = 32'(z) * HASH_Z;
    h = seed_q ^ salt ^ xm ^ zm;
    h = (h ^ (h >> 13)) * HASH_M;
    h = h ^ (h >> 16);
    n = h[15:0];
    return n + (n >> 15);
  endfunction

  function automatic longint unsigned smoothstep_q16(longint unsigned t);
    longint unsigned tc;
    tc = (t > 65536) ? 65536 : t;
    return ((tc * tc) * (196608 - 2 * tc)) >> 32;
  endfunction

  function automatic longint unsigned cell_fraction(int fr, int f);
    if (fr <= 0) return 0;
    return (longint'(fr) << 16) / f;
  endfunction

  function automatic longint unsigned lerp_q16(longint unsigned a, longint unsigned b,
                                              longint unsigned t);
    return (a * (65536 - t) + b * t) >> 16;
  endfunction

  function automatic longint unsigned value_noise(int wx, int wz, int f, logic [31:0] salt);
    int cx;
    int cz;
    longint unsigned tx;
    longint unsigned tz;
    cx = wx / f;
    cz = wz / f;
    tx = smoothstep_q16(cell_fraction(wx - cx * f, f));
    tz = smoothstep_q16(cell_fraction(wz - cz * f, f));
    return lerp_q16(lerp_q16(corner_value(cx, cz, salt), corner_value(cx + 1, cz, salt), tx),
                    lerp_q16(corner_value(cx, cz + 1, salt),
                             corner_value(cx + 1, cz + 1, salt), tx), tz);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned origin_falloff(int wx, int wz);
    longint unsigned d2;
    longint unsigned r;
    longint unsigned u;
    d2 = longint'(wx) * wx + longint'(wz) * wz;
    if (d2 >= 161604) return 0;
    r = int_sqrt(d2 << 32);
    u = (r <= 234 * 65536) ? 0 : (r - 234 * 65536) / 168;
    return 65536 - smoothstep_q16(u);
  endfunction

  function automatic terrain_pt_t predict_point(logic [14:0] cc, logic [14:0] cr,
                                                logic [4:0] xc, logic [4:0] zc);
    int wx;
    int wz;
    longint unsigned macro_n, medium_n, detail_n, ridged, acc, land;
    longint unsigned humid, rough, coast;
    terrain_pt_t p;
    wx = int'($signed(cc)) * 32 + int'(xc);
    wz = int'($signed(cr)) * 32 + int'(zc);
    macro_n = value_noise(wx, wz, 96, 32'd17);
    medium_n = value_noise(wx, wz, 28, 32'd53);
    detail_n = value_noise(wx, wz, 8, 32'd131);
    ridged = (2 * detail_n >= 65536) ? 65536 - (2 * detail_n - 65536)
                                     : 65536 - (65536 - 2 * detail_n);
    acc = macro_n * W_MACRO + medium_n * W_MEDIUM + ridged * W_RIDGE
        + origin_falloff(wx, wz) * W_ORIGIN;
    land = acc >> 16;
    if (land > 65536) land = 65536;
    p.height = 8'((land * 255) >> 16);
    humid = value_noise(wx, wz, 36, 32'd181);
    rough = value_noise(wx, wz, 18, 32'd227);
    coast = value_noise(wx, wz, 14, 32'd269);
    if (p.height < H_WATER) p.biome = TER_WATER;
    else if (p.height < H_PLAINS)
      p.biome = (coast * 25 > 13 * 65536) ? TER_PLAINS : TER_WATER;
    else if (p.height < H_FOREST)
      p.biome = (humid * 20 > 11 * 65536) ? TER_FOREST : TER_PLAINS;
    else if (p.height < H_HILL)
      p.biome = (rough * 5 > 3 * 65536) ? TER_RIDGE : TER_HILL;
    else p.biome = TER_RIDGE;
    return p;
  endfunction

  always @(posedge clk) begin
    terrain_pt_t got;
    terrain_pt_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (cfg_wr_en) seed_q <= cfg_wr_data;
      if (start && !busy) begin
        pending_pts.push_back(predict_point(in_chunk_col, in_chunk_row,
                                            in_cell_col, in_cell_row));
      end
      if (out_valid) begin
        got.height = out_height;
        got.biome = biome_t'(out_biome);
        if (pending_pts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction h=%0d b=%0d", out_height, out_biome);
        end else begin
          want = pending_pts.pop_front();
          if (got.height !== want.height || got.biome !== want.biome) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected h=%0d b=%0d, got h=%0d b=%0d",
                       want.height, want.biome, out_height, out_biome);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_point(int cc, int cr, logic [4:0] xc, logic [4:0] zc);
    if (allow_idle && $urandom_range(99) < 5) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_chunk_col <= 15'(cc);
    in_chunk_row <= 15'(cr);
    in_cell_col <= xc;
    in_cell_row <= zc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_point();
    int mode;
    int cc;
    int cr;
    mode = $urandom_range(99);
    if (mode < 55) begin
      cc = $urandom_range(27) - 14;
      cr = $urandom_range(27) - 14;
    end else if (mode < 85) begin
      cc = $urandom_range(400) - 200;
      cr = $urandom_range(400) - 200;
    end else begin
      cc = int'($signed(15'($urandom)));
      cr = int'($signed(15'($urandom)));
    end
    send_point(cc, cr, 5'($urandom), 5'($urandom));
  endtask

  point_row_t directed_rows [21] = '{
    '{0, 0, 5'd0, 5'd0}, '{0, 0, 5'd31, 5'd31}, '{-1, -1, 5'd0, 5'd0},
    '{-1, -1, 5'd31, 5'd31}, '{-1, 0, 5'd5, 5'd17}, '{-3, -2, 5'd9, 5'd30},
    '{16383, 16383, 5'd31, 5'd31}, '{-16384, -16384, 5'd0, 5'd0},
    '{16383, -16384, 5'd0, 5'd31}, '{-16384, 16383, 5'd31, 5'd0},
    '{7, 0, 5'd10, 5'd0}, '{7, 0, 5'd11, 5'd0}, '{0, -8, 5'd0, 5'd22},
    '{12, 0, 5'd17, 5'd0}, '{12, 0, 5'd18, 5'd0}, '{-13, 0, 5'd14, 5'd0},
    '{8, 8, 5'd9, 5'd9}, '{3, 0, 5'd0, 5'd0}, '{2, 2, 5'd31, 5'd31},
    '{-100, 250, 5'd13, 5'd2}, '{5461, -5462, 5'd21, 5'd10}
  };

  initial begin
    logic [31:0] seeds[5];
    seeds = '{32'h0, 32'hFFFFFFFF, $urandom, $urandom, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i])
      send_point(directed_rows[i].chunk_col, directed_rows[i].chunk_row,
                 directed_rows[i].cell_col, directed_rows[i].cell_row);
    wait_drained();
    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      if (p == 2) begin
        send_point(0, 0, 5'd0, 5'd0);
        send_point(16383, -16384, 5'd31, 5'd0);
      end
      allow_idle = (p != 3);
      repeat (RANDOM_PER_PHASE) send_random_point();
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
